// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// consequent must hold at the same edge as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold at the edge after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/dcw_pkg.sv =====
// ----------------------------------------------------------------------------
// dcw_pkg
// Types, frame geometry, register indexes and the 4x4 ordered dither matrix
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcw_pkg;

    localparam int FRAME_WIDTH  = 240;
    localparam int FRAME_HEIGHT = 240;

    localparam int DIM_W = 10;
    localparam int PIX_W = 8;
    localparam int CFG_IDX_W = 2;

    typedef logic [DIM_W-1:0]     t_dim;
    typedef logic [PIX_W-1:0]     t_pix;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_dim COL_LAST = t_dim'(FRAME_WIDTH - 1);
    localparam t_dim ROW_LAST = t_dim'(FRAME_HEIGHT - 1);
    localparam t_dim BOX_LEFT_RST = t_dim'(FRAME_WIDTH);
    localparam t_dim BOX_TOP_RST  = t_dim'(FRAME_HEIGHT);

    localparam t_pix DITHER_BAND_RST = t_pix'(15);

    localparam t_cfg_idx CFG_PREV_PROGRESS = 2'd0;
    localparam t_cfg_idx CFG_CUR_PROGRESS  = 2'd1;
    localparam t_cfg_idx CFG_DITHER_BAND   = 2'd2;

    // 4x4 bayer threshold, indexed by low bits of row and column
    function automatic logic [3:0] bayer_lookup(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] v;
        case ({row, col})
            4'h0: v = 4'd0;
            4'h1: v = 4'd8;
            4'h2: v = 4'd2;
            4'h3: v = 4'd10;
            4'h4: v = 4'd12;
            4'h5: v = 4'd4;
            4'h6: v = 4'd14;
            4'h7: v = 4'd6;
            4'h8: v = 4'd3;
            4'h9: v = 4'd11;
            4'ha: v = 4'd1;
            4'hb: v = 4'd9;
            4'hc: v = 4'd15;
            4'hd: v = 4'd7;
            4'he: v = 4'd13;
            4'hf: v = 4'd5;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/dithered_clock_wipe_pixel_top.sv =====
// ----------------------------------------------------------------------------
// dithered_clock_wipe_pixel_top
// Clock-wipe transition with an ordered-dither leading edge. Pixels arrive in
// raster order with their sweep angle; each leaves as the old or new value
// along with the running dirty rectangle of the frame. One pixel per clock is
// taken and each result appears in the cycle after its beat is accepted: the
// decision, the dither threshold (4-bit by 8-bit product) and the box update
// sit between the input handshake and a single output register. The input is
// ready while that register is empty or being read in the same cycle, so a
// stalled result holds the input back until the result side takes it.
// The rectangle is final on the beat flagged end_of_frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dithered_clock_wipe_pixel_top
    import dcw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,

    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  t_cfg_idx i_cfg_index,
    input  t_pix     i_cfg_data,

    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_start_frame,
    input  t_pix     i_sweep_angle,
    input  t_pix     i_old_pixel,
    input  t_pix     i_new_pixel,

    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pix     o_pixel_out,
    output logic     o_switched,
    output logic     o_end_of_frame,
    output logic     o_rect_valid,
    output t_dim     o_rect_left,
    output t_dim     o_rect_top,
    output t_dim     o_rect_right,
    output t_dim     o_rect_bottom
);

    // configuration
    t_pix r_prev_progress;
    t_pix r_cur_progress;
    t_pix r_dither_band;

    // raster position and box
    t_dim r_col, n_col;
    t_dim r_row, n_row;
    t_dim r_box_left, n_box_left;
    t_dim r_box_top, n_box_top;
    t_dim r_box_right, n_box_right;
    t_dim r_box_bottom, n_box_bottom;
    logic r_box_any, n_box_any;

    // result register
    logic r_out_valid;
    t_pix r_pixel_out;
    logic r_switched;
    logic r_eof;
    logic r_rect_valid;
    t_dim r_rect_left;
    t_dim r_rect_top;
    t_dim r_rect_right;
    t_dim r_rect_bottom;

    logic        in_fire;
    t_dim        col;
    t_dim        row;
    logic        box_clear;
    logic        in_range;
    t_pix        diff;
    logic [11:0] thr_prod;
    t_pix        thr;
    logic        take;
    logic        last_col;
    logic        last_row;
    logic        box_any_cur;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    always_comb begin
        col = i_start_frame ? '0 : r_col;
        row = i_start_frame ? '0 : r_row;
        box_clear   = (col == '0) && (row == '0);
        box_any_cur = r_box_any && !box_clear;

        in_range = (i_sweep_angle > r_prev_progress) && (i_sweep_angle <= r_cur_progress);
        diff     = i_sweep_angle - r_cur_progress;
        thr_prod = 12'(bayer_lookup(row[1:0], col[1:0])) * 12'(r_dither_band);
        thr      = thr_prod[11:4];
        take     = in_range || ((diff < r_dither_band) && (diff < thr));

        n_box_left   = r_box_left;
        n_box_top    = r_box_top;
        n_box_right  = r_box_right;
        n_box_bottom = r_box_bottom;
        n_box_any    = box_any_cur;
        if (box_clear) begin
            n_box_left   = BOX_LEFT_RST;
            n_box_top    = BOX_TOP_RST;
            n_box_right  = '0;
            n_box_bottom = '0;
        end
        if (take) begin
            n_box_any = 1'b1;
            if (!box_any_cur) begin
                n_box_left   = col;
                n_box_right  = col;
                n_box_top    = row;
                n_box_bottom = row;
            end else begin
                if (col < r_box_left)   n_box_left   = col;
                if (col > r_box_right)  n_box_right  = col;
                if (row < r_box_top)    n_box_top    = row;
                if (row > r_box_bottom) n_box_bottom = row;
            end
        end

        // a counter at or past its limit counts as the last one
        last_col = col >= COL_LAST;
        last_row = row >= ROW_LAST;
        if (!last_col) begin
            n_col = col + t_dim'(1);
            n_row = row;
        end else if (!last_row) begin
            n_col = '0;
            n_row = row + t_dim'(1);
        end else begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_progress <= '0;
            r_cur_progress  <= '0;
            r_dither_band   <= DITHER_BAND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PREV_PROGRESS: r_prev_progress <= i_cfg_data;
                CFG_CUR_PROGRESS:  r_cur_progress  <= i_cfg_data;
                CFG_DITHER_BAND:   r_dither_band   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_box_left   <= BOX_LEFT_RST;
            r_box_top    <= BOX_TOP_RST;
            r_box_right  <= '0;
            r_box_bottom <= '0;
            r_box_any    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_box_left   <= n_box_left;
                r_box_top    <= n_box_top;
                r_box_right  <= n_box_right;
                r_box_bottom <= n_box_bottom;
                r_box_any    <= n_box_any;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pixel_out   <= take ? i_new_pixel : i_old_pixel;
            r_switched    <= take;
            r_eof         <= last_col && last_row;
            r_rect_valid  <= n_box_any;
            r_rect_left   <= n_box_any ? n_box_left   : '0;
            r_rect_top    <= n_box_any ? n_box_top    : '0;
            r_rect_right  <= n_box_any ? n_box_right  : '0;
            r_rect_bottom <= n_box_any ? n_box_bottom : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_pixel_out;
    assign o_switched     = r_switched;
    assign o_end_of_frame = r_eof;
    assign o_rect_valid   = r_rect_valid;
    assign o_rect_left    = r_rect_left;
    assign o_rect_top     = r_rect_top;
    assign o_rect_right   = r_rect_right;
    assign o_rect_bottom  = r_rect_bottom;

    `ASSERT_IMPLIES(a_switch_marks_rect, r_out_valid && r_switched, r_rect_valid)
    `ASSERT_IMPLIES(a_rect_ordered, r_out_valid && r_rect_valid, (r_rect_left <= r_rect_right) && (r_rect_top <= r_rect_bottom))
    `ASSERT_NEXT(a_eof_wraps_raster, in_fire && last_col && last_row, (r_col == '0) && (r_row == '0) && r_eof)
    `ASSERT_ALWAYS(a_col_in_frame, r_col <= COL_LAST)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dithered clock-wipe pixel stage. Pixels are
// streamed through the input channel while a local predictor tracks the
// raster position, the dithered switch decision and the dirty rectangle.
// Every output beat is compared field by field against the oldest
// prediction. Directed cases, a full line with column wrap and randomised
// traffic under several idle and back-pressure mixes are run in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import dcw_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam t_cfg_idx CFG_UNMAPPED = 2'd3;
    // 4x4 ordered dither thresholds, one nibble per {row[1:0], col[1:0]}
    localparam logic [63:0] BAYER_NIBBLES = 64'h5D7F_91B3_6E4C_A280;

    typedef struct packed {
        t_pix pix;
        logic sw;
        logic eof;
        logic rv;
        t_dim left;
        t_dim top;
        t_dim right;
        t_dim bottom;
    } t_wipe_result;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index;
    t_pix     i_cfg_data;
    logic     i_in_valid;
    logic     o_in_ready;
    logic     i_start_frame;
    t_pix     i_sweep_angle;
    t_pix     i_old_pixel;
    t_pix     i_new_pixel;
    logic     o_out_valid;
    logic     i_out_ready;
    t_pix     o_pixel_out;
    logic     o_switched;
    logic     o_end_of_frame;
    logic     o_rect_valid;
    t_dim     o_rect_left;
    t_dim     o_rect_top;
    t_dim     o_rect_right;
    t_dim     o_rect_bottom;

    // predictor state
    t_pix cfg_prev;
    t_pix cfg_cur;
    t_pix cfg_band;
    t_dim pos_col;
    t_dim pos_row;
    t_dim box_l;
    t_dim box_t;
    t_dim box_r;
    t_dim box_b;
    logic box_hit;

    t_wipe_result wipe_results_due[$];
    int mismatches = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    dithered_clock_wipe_pixel_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_frame  (i_start_frame),
        .i_sweep_angle  (i_sweep_angle),
        .i_old_pixel    (i_old_pixel),
        .i_new_pixel    (i_new_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_switched     (o_switched),
        .o_end_of_frame (o_end_of_frame),
        .o_rect_valid   (o_rect_valid),
        .o_rect_left    (o_rect_left),
        .o_rect_top     (o_rect_top),
        .o_rect_right   (o_rect_right),
        .o_rect_bottom  (o_rect_bottom)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // random back-pressure on the result side
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_wipe_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (wipe_results_due.size() == 0) begin
                report_mismatch("result beat with no pixel outstanding");
            end else begin
                want = wipe_results_due.pop_front();
                if (o_pixel_out !== want.pix)
                    report_mismatch($sformatf("pixel_out %0d, want %0d", o_pixel_out, want.pix));
                if (o_switched !== want.sw)
                    report_mismatch($sformatf("switched %0b, want %0b", o_switched, want.sw));
                if (o_end_of_frame !== want.eof)
                    report_mismatch($sformatf("end_of_frame %0b, want %0b",
                                              o_end_of_frame, want.eof));
                if (o_rect_valid !== want.rv)
                    report_mismatch($sformatf("rect_valid %0b, want %0b", o_rect_valid, want.rv));
                if (o_rect_left !== want.left)
                    report_mismatch($sformatf("rect_left %0d, want %0d", o_rect_left, want.left));
                if (o_rect_top !== want.top)
                    report_mismatch($sformatf("rect_top %0d, want %0d", o_rect_top, want.top));
                if (o_rect_right !== want.right)
                    report_mismatch($sformatf("rect_right %0d, want %0d",
                                              o_rect_right, want.right));
                if (o_rect_bottom !== want.bottom)
                    report_mismatch($sformatf("rect_bottom %0d, want %0d",
                                              o_rect_bottom, want.bottom));
            end
        end
    end

    task automatic clear_dirty_box;
        box_l = BOX_LEFT_RST;
        box_t = BOX_TOP_RST;
        box_r = '0;
        box_b = '0;
        box_hit = 1'b0;
    endtask

    // works out the wipe decision and running dirty box for one pixel
    task automatic predict_pixel(input logic sf, input t_pix ang, input t_pix oldp,
                                 input t_pix newp);
        t_wipe_result r;
        t_pix diff;
        logic [3:0] nib;
        int thr;
        logic take;
        logic last_col;
        logic last_row;
        if (sf) begin
            pos_col = '0;
            pos_row = '0;
        end
        if (pos_col == '0 && pos_row == '0) clear_dirty_box();

        nib = BAYER_NIBBLES[4 * {pos_row[1:0], pos_col[1:0]} +: 4];
        thr = int'(nib) * int'(cfg_band) / 16;
        diff = ang - cfg_cur;
        take = (ang > cfg_prev && ang <= cfg_cur)
               || (diff < cfg_band && int'(diff) < thr);

        if (take) begin
            if (!box_hit) begin
                box_l = pos_col;
                box_r = pos_col;
                box_t = pos_row;
                box_b = pos_row;
                box_hit = 1'b1;
            end else begin
                if (pos_col < box_l) box_l = pos_col;
                if (pos_col > box_r) box_r = pos_col;
                if (pos_row < box_t) box_t = pos_row;
                if (pos_row > box_b) box_b = pos_row;
            end
        end

        last_col = (pos_col >= COL_LAST);
        last_row = (pos_row >= ROW_LAST);
        r.pix = take ? newp : oldp;
        r.sw = take;
        r.eof = last_col && last_row;
        r.rv = box_hit;
        r.left = box_hit ? box_l : '0;
        r.top = box_hit ? box_t : '0;
        r.right = box_hit ? box_r : '0;
        r.bottom = box_hit ? box_b : '0;
        wipe_results_due.push_back(r);

        if (!last_col) begin
            pos_col = pos_col + 1'b1;
        end else if (!last_row) begin
            pos_col = '0;
            pos_row = pos_row + 1'b1;
        end else begin
            pos_col = '0;
            pos_row = '0;
        end
    endtask

    task automatic send_pixel(input logic sf, input t_pix ang, input t_pix oldp,
                              input t_pix newp);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_start_frame <= sf;
        i_sweep_angle <= ang;
        i_old_pixel <= oldp;
        i_new_pixel <= newp;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pixel(sf, ang, oldp, newp);
    endtask

    // stop the pixel stream and let every result come out
    task automatic drain_pixels;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (wipe_results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_pix val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PREV_PROGRESS: cfg_prev = val;
            CFG_CUR_PROGRESS:  cfg_cur = val;
            CFG_DITHER_BAND:   cfg_band = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sweep(input t_pix prev, input t_pix cur, input t_pix band);
        drain_pixels();
        write_reg(CFG_PREV_PROGRESS, prev);
        write_reg(CFG_CUR_PROGRESS, cur);
        write_reg(CFG_DITHER_BAND, band);
    endtask

    // angles clustered around the range edges and the dithered band
    function automatic t_pix angle_near_sweep();
        t_pix a;
        case ($urandom_range(3))
            0: a = t_pix'($urandom);
            1: a = cfg_cur + t_pix'($urandom_range(int'(cfg_band)));
            2: a = cfg_prev + t_pix'($urandom_range(int'(cfg_cur - cfg_prev)));
            default: begin
                case ($urandom_range(3))
                    0: a = cfg_prev;
                    1: a = cfg_prev + 1'b1;
                    2: a = cfg_cur;
                    default: a = cfg_cur + 1'b1;
                endcase
            end
        endcase
        return a;
    endfunction

    // reset settings: range empty, band 15, dithering alone decides
    task automatic test_default_dither;
        send_pixel(1'b1, 8'd0,   8'd0,   8'd255);
        send_pixel(1'b0, 8'd5,   8'd255, 8'd0);
        send_pixel(1'b0, 8'd0,   8'd17,  8'd200);
        send_pixel(1'b0, 8'd14,  8'd0,   8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd0);
        send_pixel(1'b0, 8'd6,   8'd1,   8'd254);
    endtask

    task automatic test_range_edges;
        set_sweep(8'd10, 8'd20, 8'd15);
        send_pixel(1'b0, 8'd10,  8'd0,   8'd255);
        send_pixel(1'b0, 8'd11,  8'd0,   8'd255);
        send_pixel(1'b0, 8'd20,  8'd255, 8'd0);
        send_pixel(1'b0, 8'd21,  8'd255, 8'd0);
        // restart mid-line, box must clear
        send_pixel(1'b1, 8'd15,  8'd3,   8'd4);
        send_pixel(1'b0, 8'd30,  8'd3,   8'd4);
        send_pixel(1'b0, 8'd255, 8'd3,   8'd4);
    endtask

    task automatic test_empty_range_zero_band;
        set_sweep(8'd200, 8'd100, 8'd0);
        write_reg(CFG_UNMAPPED, 8'hA5);
        send_pixel(1'b1, 8'd150, 8'd0,   8'd255);
        send_pixel(1'b0, 8'd100, 8'd255, 8'd0);
        send_pixel(1'b0, 8'd200, 8'd0,   8'd255);
        send_pixel(1'b0, 8'd101, 8'd255, 8'd0);
    endtask

    task automatic test_full_band;
        set_sweep(8'd255, 8'd255, 8'd255);
        send_pixel(1'b1, 8'd0,   8'd0,   8'd255);
        send_pixel(1'b0, 8'd100, 8'd0,   8'd255);
        send_pixel(1'b0, 8'd254, 8'd255, 8'd0);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd0);
    endtask

    // one whole line, then a few beats into the next row without a start flag
    task automatic test_line_wrap;
        t_pix ang;
        set_sweep(8'd100, 8'd110, 8'd0);
        for (int i = 0; i < FRAME_WIDTH + 20; i++) begin
            ang = ($urandom_range(49) == 0) ? 8'd105 : 8'd0;
            send_pixel(i == 0, ang, t_pix'($urandom), t_pix'($urandom));
        end
    endtask

    task automatic run_random_phase(input int idle, input int stall, input t_pix prev,
                                    input t_pix cur, input t_pix band);
        set_sweep(prev, cur, band);
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < 60; i++) begin
            send_pixel(i == 0 || $urandom_range(39) == 0, angle_near_sweep(),
                       t_pix'($urandom), t_pix'($urandom));
        end
    endtask

    task automatic test_random_traffic;
        run_random_phase(0, 0, 8'd0, 8'd255, 8'd255);
        run_random_phase(60, 0, t_pix'($urandom), t_pix'($urandom), t_pix'($urandom));
        run_random_phase(0, 60, 8'd255, 8'd0, 8'd0);
        run_random_phase(38, 38, t_pix'($urandom), t_pix'($urandom), t_pix'($urandom));
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_PREV_PROGRESS;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_start_frame <= 1'b0;
        i_sweep_angle <= '0;
        i_old_pixel <= '0;
        i_new_pixel <= '0;
        i_out_ready <= 1'b0;
        cfg_prev = '0;
        cfg_cur = '0;
        cfg_band = DITHER_BAND_RST;
        pos_col = '0;
        pos_row = '0;
        clear_dirty_box();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_dither();
        test_range_edges();
        test_empty_range_zero_band();
        test_full_band();
        test_line_wrap();
        test_random_traffic();

        drain_pixels();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dcw_pkg.sv
hw/rtl/dithered_clock_wipe_pixel_top.sv
tb/tb_top.sv
